@@ sv/u8nfc_pkg.sv @@
// u8nfc_pkg: shared types, constants and lookup functions for the utf-8 composer
// no dependencies
package u8nfc_pkg;

    localparam logic [20:0] HG_S = 21'h0AC00;
    localparam logic [20:0] HG_L = 21'h01100;
    localparam logic [20:0] HG_V = 21'h01161;
    localparam logic [20:0] HG_T = 21'h011A7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // one decoded code point travelling from front to back
    typedef struct packed {
        logic [20:0] cp;
        logic        flush;
        logic        has_cp;
    } cp_req_t;

    function automatic logic [2:0] need_len(input logic [7:0] c);
        logic [2:0] n;
        begin
            n = 3'd1;
            if (c[7] == 1'b0)
                n = 3'd1;
            else if (c[7:5] == 3'b110)
                n = 3'd2;
            else if (c[7:4] == 4'b1110)
                n = 3'd3;
            else if (c[7:3] == 5'b11110)
                n = 3'd4;
            return n;
        end
    endfunction

    function automatic logic [20:0] compose_pair(input logic [20:0] base,
                                                 input logic [20:0] mark);
        logic [15:0] r;
        begin
            r = 16'h0000;
            if (base[20:16] == 5'd0) begin
                case (mark)
                    21'h301:
                        case (base[15:0])
                            16'h61: r = 16'he1;
                            16'h65: r = 16'he9;
                            16'h69: r = 16'hed;
                            16'h6f: r = 16'hf3;
                            16'h75: r = 16'hfa;
                            16'h79: r = 16'hfd;
                            default: r = 16'h0;
                        endcase
                    21'h300:
                        case (base[15:0])
                            16'h61: r = 16'he0;
                            16'h65: r = 16'he8;
                            16'h69: r = 16'hec;
                            16'h6f: r = 16'hf2;
                            16'h75: r = 16'hf9;
                            default: r = 16'h0;
                        endcase
                    21'h302:
                        case (base[15:0])
                            16'h61: r = 16'he2;
                            16'h65: r = 16'hea;
                            16'h69: r = 16'hee;
                            16'h6f: r = 16'hf4;
                            16'h75: r = 16'hfb;
                            default: r = 16'h0;
                        endcase
                    21'h303:
                        case (base[15:0])
                            16'h61: r = 16'he3;
                            16'h6f: r = 16'hf5;
                            16'h6e: r = 16'hf1;
                            default: r = 16'h0;
                        endcase
                    21'h308:
                        case (base[15:0])
                            16'h65: r = 16'heb;
                            16'h69: r = 16'hef;
                            16'h75: r = 16'hfc;
                            16'h79: r = 16'hff;
                            default: r = 16'h0;
                        endcase
                    21'h327:
                        r = (base[15:0] == 16'h63) ? 16'he7 : 16'h0;
                    21'h30c:
                        case (base[15:0])
                            16'h63: r = 16'h10d;
                            16'h64: r = 16'h10f;
                            16'h65: r = 16'h11b;
                            16'h6e: r = 16'h148;
                            16'h72: r = 16'h159;
                            16'h73: r = 16'h161;
                            16'h74: r = 16'h165;
                            16'h7a: r = 16'h17e;
                            default: r = 16'h0;
                        endcase
                    21'h30a:
                        r = (base[15:0] == 16'h75) ? 16'h16f : 16'h0;
                    21'h3099:
                        case (base[15:0])
                            16'h304b: r = 16'h304c;
                            16'h304d: r = 16'h304e;
                            16'h304f: r = 16'h3050;
                            16'h3051: r = 16'h3052;
                            16'h3053: r = 16'h3054;
                            16'h3055: r = 16'h3056;
                            16'h3057: r = 16'h3058;
                            16'h3059: r = 16'h305a;
                            16'h305b: r = 16'h305c;
                            16'h305d: r = 16'h305e;
                            16'h305f: r = 16'h3060;
                            16'h3064: r = 16'h3065;
                            16'h3066: r = 16'h3067;
                            16'h3068: r = 16'h3069;
                            16'h306f: r = 16'h3070;
                            16'h3072: r = 16'h3073;
                            16'h3075: r = 16'h3076;
                            16'h3078: r = 16'h3079;
                            16'h307b: r = 16'h307c;
                            default: r = 16'h0;
                        endcase
                    21'h309a:
                        case (base[15:0])
                            16'h306f: r = 16'h3071;
                            16'h3072: r = 16'h3074;
                            16'h3075: r = 16'h3077;
                            16'h3078: r = 16'h307a;
                            16'h307b: r = 16'h307d;
                            default: r = 16'h0;
                        endcase
                    default: r = 16'h0;
                endcase
            end
            return {5'd0, r};
        end
    endfunction

endpackage

@@ sv/u8nfc_stream_if.sv @@
// u8nfc_stream_if: valid/ready byte channel with last flag
// depends on nothing
interface u8nfc_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;
    modport source (output valid, output data, output last, input ready);
    modport sink (input valid, input data, input last, output ready);
endinterface

@@ sv/u8nfc_front.sv @@
// u8nfc_front: utf-8 decoder, gathers sequences and handles cut-off tails
// depends on u8nfc_pkg and u8nfc_stream_if
module u8nfc_front
    import u8nfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    u8nfc_stream_if.sink     in_s,
    output logic             req_valid,
    output cp_req_t          req,
    input  logic             req_ready
);

    logic [7:0] seq_reg [3];
    logic [7:0] seq_next [3];
    logic [1:0] cnt_reg, cnt_next;
    // tail replay: after a last byte with leftovers, emit them over cycles
    logic       tail_reg, tail_next;
    logic [1:0] tidx_reg, tidx_next;
    logic [1:0] tn_reg, tn_next;

    logic [2:0] len0, lt;
    logic [20:0] dec;
    logic [20:0] tdec;
    logic       take;

    function automatic logic [20:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] n);
        logic [20:0] c;
        begin
            case (n)
                3'd2: c = {10'd0, b0[4:0], b1[5:0]};
                3'd3: c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                3'd4: c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default: c = {13'd0, b0};
            endcase
            return c;
        end
    endfunction

    assign len0 = need_len(seq_reg[0]);
    assign in_s.ready = !tail_reg && req_ready;
    assign take = in_s.valid && in_s.ready;
    assign lt = need_len(seq_reg[tidx_reg]);

    always_comb
    begin
        dec = decode(seq_reg[0], (cnt_reg == 2'd1) ? in_s.data : seq_reg[1],
                     (cnt_reg == 2'd2) ? in_s.data : seq_reg[2], in_s.data,
                     {1'b0, cnt_reg} + 3'd1);
        tdec = {13'd0, seq_reg[tidx_reg]};
        if (lt > 3'd1 && {1'b0, tidx_reg} + lt <= {1'b0, tn_reg})
            tdec = decode(seq_reg[tidx_reg], seq_reg[tidx_reg + 2'd1], seq_reg[2],
                          8'h00, lt);
    end

    always_comb
    begin
        seq_next = seq_reg;
        cnt_next = cnt_reg;
        tail_next = tail_reg;
        tidx_next = tidx_reg;
        tn_next = tn_reg;
        req_valid = 1'b0;
        req.cp = 21'd0;
        req.flush = 1'b0;
        req.has_cp = 1'b0;
        if (tail_reg) begin
            req_valid = 1'b1;
            req.cp = tdec;
            req.has_cp = 1'b1;
            if (lt > 3'd1 && {1'b0, tidx_reg} + lt <= {1'b0, tn_reg}) begin
                req.flush = ({1'b0, tidx_reg} + lt == {1'b0, tn_reg});
                if (req_ready)
                    tidx_next = 2'(tidx_reg + lt[1:0]);
            end else begin
                req.flush = (tidx_reg + 2'd1 == tn_reg);
                if (req_ready)
                    tidx_next = tidx_reg + 2'd1;
            end
            if (req_ready && req.flush) begin
                tail_next = 1'b0;
                cnt_next = 2'd0;
            end
        end else if (take) begin
            req_valid = 1'b1;
            if (cnt_reg == 2'd0) begin
                if (need_len(in_s.data) == 3'd1) begin
                    req.cp = {13'd0, in_s.data};
                    req.has_cp = 1'b1;
                    req.flush = in_s.last;
                end else begin
                    seq_next[0] = in_s.data;
                    cnt_next = 2'd1;
                end
            end else if ({1'b0, cnt_reg} + 3'd1 >= len0) begin
                req.cp = dec;
                req.has_cp = 1'b1;
                req.flush = in_s.last;
                cnt_next = 2'd0;
            end else begin
                seq_next[cnt_reg] = in_s.data;
                cnt_next = cnt_reg + 2'd1;
            end
            if (in_s.last && cnt_next != 2'd0) begin
                // cut-off sequence: replay held bytes one code point at a time
                req_valid = 1'b0;
                tail_next = 1'b1;
                tidx_next = 2'd0;
                tn_next = cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            tail_reg <= 1'b0;
            tidx_reg <= 2'd0;
            tn_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            tail_reg <= tail_next;
            tidx_reg <= tidx_next;
            tn_reg <= tn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

endmodule

@@ sv/u8nfc_queue.sv @@
// u8nfc_queue: short fifo of decoded code point requests between front and back
// depends on u8nfc_pkg
module u8nfc_queue
    import u8nfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    input  cp_req_t wr_data,
    output logic    wr_ready,
    output logic    rd_valid,
    output cp_req_t rd_data,
    input  logic    rd_ready
);

    cp_req_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [QUEUE_AW:0]   n_reg;

    assign wr_ready = (n_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (n_reg != '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
        end else begin
            if (wr_valid && wr_ready)
                wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready)
                rp_reg <= rp_reg + 1'b1;
            n_reg <= n_reg + (QUEUE_AW+1)'(wr_valid && wr_ready)
                     - (QUEUE_AW+1)'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

@@ sv/u8nfc_back.sv @@
// u8nfc_back: composition window, hangul and pair joining, utf-8 re-encoding
// depends on u8nfc_pkg and u8nfc_stream_if
module u8nfc_back
    import u8nfc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  cp_req_t          req,
    output logic             req_ready,
    u8nfc_stream_if.source   out_s
);

    // window of up to three code points; composition happens when full or flushing
    logic [20:0] w_reg [3];
    logic [20:0] w_next [3];
    logic [1:0]  n_reg, n_next;
    logic        fl_reg, fl_next;
    // encoder holding one composed code point
    logic [20:0] e_reg, e_next;
    logic [1:0]  ecnt_reg, ecnt_next;
    logic [1:0]  epos_reg, epos_next;
    logic        ebusy_reg, ebusy_next;
    logic        elast_reg, elast_next;
    // registered hangul products
    logic [20:0] hl_reg, hv_reg;

    logic [20:0] sel_cp;
    logic [1:0]  used;
    logic        is_lv, has_t;
    logic [20:0] pj;
    logic        work;
    logic [1:0]  elen;
    logic        enc_free;
    logic        out_take;
    logic        emit;

    assign out_take = out_s.valid && out_s.ready;
    assign enc_free = !ebusy_reg || (out_take && epos_reg == ecnt_reg);
    assign work = (n_reg == 2'd3) || (fl_reg && n_reg != 2'd0);
    assign req_ready = !work && !(fl_reg && n_reg == 2'd0 && 1'b0);

    assign is_lv = (n_reg >= 2'd2) && w_reg[0] >= HG_L && w_reg[0] < HG_L + 21'd19
                   && w_reg[1] >= HG_V && w_reg[1] < HG_V + 21'd21;
    assign has_t = (n_reg == 2'd3) && w_reg[2] > HG_T && w_reg[2] <= HG_T + 21'd27;
    assign pj = compose_pair(w_reg[0], w_reg[1]);

    always_ff @(posedge clk)
    begin
        hl_reg <= 21'((w_reg[0] - HG_L) * 21'd588);
        hv_reg <= 21'((w_reg[1] - HG_V) * 21'd28);
    end

    // hangul uses the products registered from the window a cycle ago
    logic hwait_reg, hwait_next;

    always_comb
    begin
        used = 2'd1;
        sel_cp = w_reg[0];
        if (is_lv) begin
            used = has_t ? 2'd3 : 2'd2;
            sel_cp = HG_S + hl_reg + hv_reg + (has_t ? w_reg[2] - HG_T : 21'd0);
        end else if (n_reg >= 2'd2 && pj != 21'd0) begin
            used = 2'd2;
            sel_cp = pj;
        end
    end

    assign emit = work && enc_free && !(is_lv && hwait_reg);

    always_comb
    begin
        w_next = w_reg;
        n_next = n_reg;
        fl_next = fl_reg;
        hwait_next = 1'b0;
        if (emit) begin
            case (used)
                2'd2:
                begin
                    w_next[0] = w_reg[2];
                end
                2'd3:
                begin
                    w_next[0] = w_reg[0];
                end
                default:
                begin
                    w_next[0] = w_reg[1];
                    w_next[1] = w_reg[2];
                end
            endcase
            n_next = n_reg - used;
            if (n_next == 2'd0)
                fl_next = 1'b0;
            hwait_next = 1'b1;
        end else if (req_valid && req_ready) begin
            if (req.has_cp) begin
                w_next[n_reg] = req.cp;
                n_next = n_reg + 2'd1;
            end
            fl_next = req.flush;
            hwait_next = 1'b1;
        end else if (work && is_lv && hwait_reg) begin
            hwait_next = 1'b0;
        end
    end

    always_comb
    begin
        if (sel_cp < 21'h80)
            elen = 2'd0;
        else if (sel_cp < 21'h800)
            elen = 2'd1;
        else if (sel_cp < 21'h10000)
            elen = 2'd2;
        else
            elen = 2'd3;
    end

    always_comb
    begin
        e_next = e_reg;
        ecnt_next = ecnt_reg;
        epos_next = epos_reg;
        ebusy_next = ebusy_reg;
        elast_next = elast_reg;
        if (out_take) begin
            epos_next = epos_reg + 2'd1;
            if (epos_reg == ecnt_reg)
                ebusy_next = 1'b0;
        end
        if (emit) begin
            e_next = sel_cp;
            ecnt_next = elen;
            epos_next = 2'd0;
            ebusy_next = 1'b1;
            elast_next = fl_reg && (n_reg == used);
        end
    end

    always_comb
    begin
        out_s.valid = ebusy_reg;
        out_s.last = elast_reg && (epos_reg == ecnt_reg);
        case (ecnt_reg)
            2'd0: out_s.data = e_reg[7:0];
            2'd1: out_s.data = (epos_reg == 2'd0) ? {3'b110, e_reg[10:6]}
                                                   : {2'b10, e_reg[5:0]};
            2'd2:
                case (epos_reg)
                    2'd0: out_s.data = {4'b1110, e_reg[15:12]};
                    2'd1: out_s.data = {2'b10, e_reg[11:6]};
                    default: out_s.data = {2'b10, e_reg[5:0]};
                endcase
            default:
                case (epos_reg)
                    2'd0: out_s.data = {5'b11110, e_reg[20:18]};
                    2'd1: out_s.data = {2'b10, e_reg[17:12]};
                    2'd2: out_s.data = {2'b10, e_reg[11:6]};
                    default: out_s.data = {2'b10, e_reg[5:0]};
                endcase
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n_reg <= 2'd0;
            fl_reg <= 1'b0;
            ebusy_reg <= 1'b0;
            ecnt_reg <= 2'd0;
            epos_reg <= 2'd0;
            elast_reg <= 1'b0;
            hwait_reg <= 1'b0;
        end else begin
            n_reg <= n_next;
            fl_reg <= fl_next;
            ebusy_reg <= ebusy_next;
            ecnt_reg <= ecnt_next;
            epos_reg <= epos_next;
            elast_reg <= elast_next;
            hwait_reg <= hwait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        e_reg <= e_next;
    end

endmodule

@@ sv/utf8_nfc_composer_top.sv @@
// utf8_nfc_composer_top: streaming utf-8 composer, hangul and base-plus-mark joining
// the byte that fills the window or ends the string passes queue, window and encoder register
// before output, hangul also awaiting its products; throughput: one input byte, or in a cut-off
// tail one held byte or sequence, a cycle while the four-deep queue has room; the back takes a
// request only when not joining, so single-byte code points alternate with emits; a multi-byte
// code point holds the encoder to its last byte; reset: rst_n asynchronous, clears control state
module utf8_nfc_composer_top
    import u8nfc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    u8nfc_stream_if.sink   in_s,
    u8nfc_stream_if.source out_s
);

    logic    f_valid, f_ready, q_valid, q_ready;
    cp_req_t f_req, q_req;

    u8nfc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_s(in_s),
        .req_valid(f_valid), .req(f_req), .req_ready(f_ready)
    );

    u8nfc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_data(f_req), .wr_ready(f_ready),
        .rd_valid(q_valid), .rd_data(q_req), .rd_ready(q_ready)
    );

    u8nfc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .req_valid(q_valid), .req(q_req), .req_ready(q_ready), .out_s(out_s)
    );

endmodule
